// ===== hdl/console_text_cell_writer_core_defines.svh =====
// assertion macros shared by the console text cell writer rtl
// needs a clock named clk and an active-low reset named arst_n in the using module
`ifndef CONSOLE_TEXT_CELL_WRITER_CORE_DEFINES_SVH
`define CONSOLE_TEXT_CELL_WRITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define CTCW_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ctcw assertion failed");
// antecedent in one cycle implies consequent in the next
`define CTCW_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctcw assertion failed");
`else
`define CTCW_ASSERT(name, prop)
`define CTCW_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hdl/ctcw_pkg.sv =====
// types, codes and constants for the console text cell writer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctcw_pkg;

	localparam int ROWS_DEF = 32;
	localparam int COLS_DEF = 128;

	typedef logic [7:0] ctcw_cell_t;

	// character codes
	localparam ctcw_cell_t CH_NUL   = 8'h00;
	localparam ctcw_cell_t CH_BS    = 8'h08;
	localparam ctcw_cell_t CH_TAB   = 8'h09;
	localparam ctcw_cell_t CH_NL    = 8'h0A;
	localparam ctcw_cell_t CH_CR    = 8'h0D;
	localparam ctcw_cell_t CH_SPACE = 8'h20;

	// tab stops every four columns
	localparam logic [2:0] TAB_STOP = 3'd4;
	localparam int         TAB_BITS = 2;

	typedef enum logic [2:0] {
		FN_WRITE    = 3'd0,
		FN_SETCUR   = 3'd1,
		FN_CLEAR    = 3'd2,
		FN_READ     = 3'd3,
		FN_CLRDIRTY = 3'd4
	} ctcw_func_t;

	typedef struct packed {
		logic [2:0] func;
		ctcw_cell_t ch;
		logic [6:0] col;
		logic [4:0] row;
	} ctcw_in_t;

	typedef struct packed {
		ctcw_cell_t cell_value;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       dirty;
		logic       scrolled;
	} ctcw_out_t;

	// cell ram control from the sequencer
	typedef struct packed {
		logic wr;       // write wr_data at wr_row/wr_col
		logic clr_all;  // mark every row empty
		logic kill;     // mark wr_row empty
		logic mark;     // mark wr_row filled
	} ctcw_ram_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CLR,
		ST_SCAN,
		ST_PAD,
		ST_PUT,
		ST_TERM,
		ST_TAB_RD,
		ST_TAB_WR,
		ST_TAB_Z,
		ST_ADV,
		ST_RD_WAIT,
		ST_FIN
	} ctcw_state_t;

endpackage

`default_nettype wire

// ===== hdl/ctcw_chan_if.sv =====
// valid/ready channel carrying one payload struct
// payload type comes from ctcw_pkg at the instance
`timescale 1ns / 1ps
`default_nettype none

interface ctcw_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/console_text_cell_writer_core.sv =====
// console text cell writer: one request in, one result out, items worked one at a time.
// a printable byte walks the columns of its line over the cell ram, and a tab walks on to the next
// tab stop; either first wipes its line when that line is still marked empty.
// a new request is taken once back in idle.
// reset: cursor home, dirty set, every row marked empty; ready right after reset, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module console_text_cell_writer_core
	import ctcw_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ctcw_chan_if.sink   req,
	ctcw_chan_if.source rsp
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);

	// sequencer handshake
	logic          seq_idle;
	logic          seq_done;
	logic          seq_take;
	logic          start;
	ctcw_out_t     seq_res;

	// cell ram port
	ctcw_ram_ctl_t ram_ctl;
	logic [RW-1:0] wr_row;
	logic [CW-1:0] wr_col;
	ctcw_cell_t    wr_data;
	logic [RW-1:0] rd_row;
	logic [CW-1:0] rd_col;
	ctcw_cell_t    rd_data;
	logic          wr_row_vld;

	// result register, parts the sequencer from the result channel
	logic          rsp_vld_q;
	ctcw_out_t     rsp_data_q;

	// a request transfer only happens while the sequencer sits idle
	assign req.ready = seq_idle;
	assign start     = req.valid && req.ready;

	// finished item moves into the result register when it is empty or being drained
	assign seq_take  = seq_done && (!rsp_vld_q || rsp.ready);

	ctcw_seq #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (req.data),
		.idle       (seq_idle),
		.done       (seq_done),
		.take       (seq_take),
		.res        (seq_res),
		.ram_ctl    (ram_ctl),
		.wr_row     (wr_row),
		.wr_col     (wr_col),
		.wr_data    (wr_data),
		.rd_row     (rd_row),
		.rd_col     (rd_col),
		.rd_data    (rd_data),
		.wr_row_vld (wr_row_vld)
	);

	// screen cells, rows addressed through the scroll base inside the sequencer
	ctcw_screen_ram #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_ram (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ram_ctl),
		.wr_row     (wr_row),
		.wr_col     (wr_col),
		.wr_data    (wr_data),
		.rd_row     (rd_row),
		.rd_col     (rd_col),
		.rd_data    (rd_data),
		.wr_row_vld (wr_row_vld)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (seq_take) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// result payload, held while the transfer is stalled
	always_ff @(posedge clk) begin
		if (seq_take) begin
			rsp_data_q <= seq_res;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_data_q;

endmodule

`default_nettype wire

// ===== hdl/ctcw_screen_ram.sv =====
// screen cell ram with one write and one registered read port, plus row filled bits
// depends on ctcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctcw_screen_ram
	import ctcw_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctcw_ram_ctl_t             ctl,
	input  logic [$clog2(ROWS)-1:0]   wr_row,
	input  logic [$clog2(COLS)-1:0]   wr_col,
	input  ctcw_cell_t                wr_data,
	input  logic [$clog2(ROWS)-1:0]   rd_row,
	input  logic [$clog2(COLS)-1:0]   rd_col,
	output ctcw_cell_t                rd_data,
	output logic                      wr_row_vld
);

	localparam int CW    = $clog2(COLS);
	localparam int DEPTH = ROWS << CW;

	ctcw_cell_t        mem_q [DEPTH];
	ctcw_cell_t        rd_data_q;
	logic              rd_vld_q;
	logic [ROWS-1:0]   row_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[{wr_row, wr_col}] <= wr_data;
		end
		rd_data_q <= mem_q[{rd_row, rd_col}];
	end

	// an empty row reads as zero whatever the ram holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= row_vld_q[rd_row];
			priority if (ctl.clr_all) begin
				row_vld_q <= '0;
			end else if (ctl.kill) begin
				row_vld_q[wr_row] <= 1'b0;
			end else if (ctl.mark) begin
				row_vld_q[wr_row] <= 1'b1;
			end
		end
	end

	assign rd_data    = rd_vld_q ? rd_data_q : CH_NUL;
	assign wr_row_vld = row_vld_q[wr_row];

endmodule

`default_nettype wire

// ===== hdl/ctcw_seq.sv =====
// sequencer: cursor, scroll base and the column walk over the cell ram
// depends on ctcw_pkg and the assertion macros header
`timescale 1ns / 1ps
`default_nettype none
`include "console_text_cell_writer_core_defines.svh"

module ctcw_seq
	import ctcw_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  ctcw_in_t                  cmd,
	output logic                      idle,
	output logic                      done,
	input  logic                      take,
	output ctcw_out_t                 res,
	output ctcw_ram_ctl_t             ram_ctl,
	output logic [$clog2(ROWS)-1:0]   wr_row,
	output logic [$clog2(COLS)-1:0]   wr_col,
	output ctcw_cell_t                wr_data,
	output logic [$clog2(ROWS)-1:0]   rd_row,
	output logic [$clog2(COLS)-1:0]   rd_col,
	input  ctcw_cell_t                rd_data,
	input  logic                      wr_row_vld
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
	localparam logic [CW-1:0] COL_WRAP = CW'(COLS - 2);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);

	ctcw_state_t   st_q, st_d;
	ctcw_in_t      cmd_q;
	logic [RW-1:0] prow_q;
	logic [RW-1:0] base_q;
	logic [RW-1:0] line_q;
	logic [CW-1:0] cc_q;
	logic          dirty_q;
	logic          scrolled_q;
	ctcw_cell_t    val_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] nidx_q;
	logic [CW-1:0] rd_idx_q;
	logic          scan_vld_q;
	logic          at_end_q;
	logic          wrap_q;
	logic [2:0]    tab_left_q;
	logic          col_ok;
	logic          row_ok;

	// logical line to ram row through the scroll base
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
		input logic [RW-1:0] base);
		logic [RW:0] sum;
		sum = {1'b0, lrow} + {1'b0, base};
		if (sum >= ROWS_X) begin
			sum = sum - ROWS_X;
		end
		return sum[RW-1:0];
	endfunction

	assign col_ok = int'(cmd_q.col) < COLS;
	assign row_ok = int'(cmd_q.row) < ROWS;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					st_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (cmd_q.func)
					FN_WRITE: begin
						priority if (cmd_q.ch == CH_NUL || cmd_q.ch == CH_CR ||
							cmd_q.ch == CH_BS) begin
							st_d = ST_FIN;
						end else if (cmd_q.ch == CH_NL) begin
							st_d = ST_ADV;
						end else if (!wr_row_vld) begin
							st_d = ST_CLR;
						end else if (cmd_q.ch == CH_TAB) begin
							st_d = ST_TAB_RD;
						end else begin
							st_d = ST_SCAN;
						end
					end
					FN_READ: st_d = ST_RD_WAIT;
					default: st_d = ST_FIN;
				endcase
			end
			ST_CLR: begin
				if (idx_q == COL_LAST) begin
					st_d = (cmd_q.ch == CH_TAB) ? ST_TAB_RD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_vld_q) begin
					priority if (rd_data == CH_NUL) begin
						st_d = (rd_idx_q != cc_q) ? ST_PAD : ST_PUT;
					end else if (rd_idx_q == cc_q) begin
						st_d = ST_PUT;
					end
				end
			end
			ST_PAD: begin
				if ((idx_q + CW'(1)) == cc_q) begin
					st_d = ST_PUT;
				end
			end
			ST_PUT:     st_d = (cc_q >= COL_WRAP || at_end_q) ? ST_TERM : ST_FIN;
			ST_TERM:    st_d = wrap_q ? ST_ADV : ST_FIN;
			ST_TAB_RD:  st_d = (tab_left_q == '0 || cc_q >= COL_LAST) ? ST_FIN : ST_TAB_WR;
			ST_TAB_WR:  st_d = (rd_data == CH_NUL) ? ST_TAB_Z : ST_TAB_RD;
			ST_TAB_Z:   st_d = ST_TAB_RD;
			ST_ADV:     st_d = ST_FIN;
			ST_RD_WAIT: st_d = ST_FIN;
			ST_FIN: begin
				if (take) begin
					st_d = ST_IDLE;
				end
			end
			default:    st_d = ST_IDLE;
		endcase
	end

	// ram port drive
	always_comb begin
		ram_ctl = '0;
		wr_row  = prow_q;
		wr_col  = cc_q;
		wr_data = CH_NUL;
		rd_row  = prow_q;
		rd_col  = cc_q;
		unique case (st_q)
			ST_DECODE: begin
				rd_row = row_ok ? phys_row(RW'(cmd_q.row), base_q) : prow_q;
				rd_col = CW'(cmd_q.col);
				ram_ctl.clr_all = (cmd_q.func == FN_CLEAR);
			end
			ST_CLR: begin
				ram_ctl.wr   = 1'b1;
				ram_ctl.mark = (idx_q == COL_LAST);
				wr_col       = idx_q;
			end
			ST_SCAN: begin
				rd_col = nidx_q;
			end
			ST_PAD: begin
				ram_ctl.wr = 1'b1;
				wr_col     = idx_q;
				wr_data    = CH_SPACE;
			end
			ST_PUT: begin
				ram_ctl.wr = 1'b1;
				wr_data    = cmd_q.ch;
			end
			ST_TERM: begin
				ram_ctl.wr = 1'b1;
				wr_col     = idx_q;
			end
			ST_TAB_WR: begin
				ram_ctl.wr = 1'b1;
				wr_data    = CH_SPACE;
			end
			ST_TAB_Z: begin
				ram_ctl.wr = 1'b1;
				wr_col     = cc_q + CW'(1);
			end
			ST_ADV: begin
				// top line leaves the screen and comes back as the empty last line
				wr_row       = base_q;
				ram_ctl.kill = (line_q == ROW_LAST);
			end
			default: ;
		endcase
	end

	// cursor, scroll base and dirty mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			base_q  <= '0;
			line_q  <= '0;
			cc_q    <= '0;
			dirty_q <= 1'b1;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_DECODE: begin
					unique case (cmd_q.func)
						FN_WRITE: begin
							if (cmd_q.ch != CH_NUL) begin
								dirty_q <= 1'b1;
							end
							if (cmd_q.ch == CH_NL || cmd_q.ch == CH_CR) begin
								cc_q <= '0;
							end
							if (cmd_q.ch == CH_BS && cc_q != '0) begin
								cc_q <= cc_q - CW'(1);
							end
						end
						FN_SETCUR: begin
							if (col_ok) begin
								cc_q <= CW'(cmd_q.col);
							end
							if (row_ok) begin
								line_q <= RW'(cmd_q.row);
							end
							dirty_q <= 1'b1;
						end
						FN_CLEAR: begin
							cc_q    <= '0;
							line_q  <= '0;
							base_q  <= '0;
							dirty_q <= 1'b1;
						end
						FN_CLRDIRTY: dirty_q <= 1'b0;
						default: ;
					endcase
				end
				ST_PUT: begin
					cc_q <= (cc_q >= COL_WRAP) ? '0 : cc_q + CW'(1);
				end
				ST_TAB_WR: begin
					if (rd_data != CH_NUL) begin
						cc_q <= cc_q + CW'(1);
					end
				end
				ST_TAB_Z: begin
					cc_q <= cc_q + CW'(1);
				end
				ST_ADV: begin
					if (line_q == ROW_LAST) begin
						base_q <= (base_q == ROW_LAST) ? '0 : base_q + RW'(1);
					end else begin
						line_q <= line_q + RW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q      <= cmd;
					prow_q     <= phys_row(line_q, base_q);
					scrolled_q <= 1'b0;
					val_q      <= CH_NUL;
				end
			end
			ST_DECODE: begin
				idx_q      <= '0;
				nidx_q     <= '0;
				scan_vld_q <= 1'b0;
				tab_left_q <= TAB_STOP - {1'b0, cc_q[TAB_BITS-1:0]};
			end
			ST_CLR: begin
				idx_q <= idx_q + CW'(1);
			end
			ST_SCAN: begin
				nidx_q     <= nidx_q + CW'(1);
				rd_idx_q   <= nidx_q;
				scan_vld_q <= 1'b1;
				if (scan_vld_q) begin
					priority if (rd_data == CH_NUL) begin
						idx_q    <= rd_idx_q;
						at_end_q <= 1'b1;
					end else if (rd_idx_q == cc_q) begin
						at_end_q <= 1'b0;
					end
				end
			end
			ST_PAD: begin
				idx_q <= idx_q + CW'(1);
			end
			ST_PUT: begin
				wrap_q <= (cc_q >= COL_WRAP);
				idx_q  <= (cc_q >= COL_WRAP) ? COL_LAST : cc_q + CW'(1);
			end
			ST_TAB_WR: begin
				if (rd_data != CH_NUL) begin
					tab_left_q <= tab_left_q - 3'd1;
				end
			end
			ST_TAB_Z: begin
				tab_left_q <= tab_left_q - 3'd1;
			end
			ST_ADV: begin
				if (line_q == ROW_LAST) begin
					scrolled_q <= 1'b1;
				end
			end
			ST_RD_WAIT: begin
				val_q <= (col_ok && row_ok) ? rd_data : CH_NUL;
			end
			default: ;
		endcase
	end

	assign idle = (st_q == ST_IDLE);
	assign done = (st_q == ST_FIN);
	assign res  = '{
		cell_value: val_q,
		cursor_col: 7'(cc_q),
		cursor_row: 5'(line_q),
		dirty:      dirty_q,
		scrolled:   scrolled_q
	};

	`CTCW_ASSERT(a_line_range, int'(line_q) < ROWS)
	`CTCW_ASSERT(a_col_range, int'(cc_q) < COLS)
	`CTCW_ASSERT(a_base_range, int'(base_q) < ROWS)
	`CTCW_ASSERT_NEXT(a_start_decode, start, st_q == ST_DECODE)
	`CTCW_ASSERT_NEXT(a_fin_hold, (st_q == ST_FIN) && !take, st_q == ST_FIN)
	`CTCW_ASSERT(a_scan_bound, !(st_q == ST_SCAN && scan_vld_q) || (rd_idx_q <= cc_q))

endmodule

`default_nettype wire
